@@ src/kme_pkg.sv @@
package kme_pkg;

  localparam int MAX_VERTICES  = 32;
  localparam int EDGE_CAPACITY = 128;
  localparam int VERT_W        = 5;
  localparam int COST_W        = 16;
  localparam int TOTAL_W       = 21;
  localparam int RANK_W        = 3;
  localparam int VC_W          = 6;
  localparam int VC_RESET      = 32;
  localparam int EADDR_W       = $clog2(EDGE_CAPACITY);
  localparam int CNT_W         = $clog2(EDGE_CAPACITY + 1);
  localparam int EDGE_W        = 2 * VERT_W + COST_W;
  localparam int UF_W          = RANK_W + VERT_W;
  localparam int UF_DEPTH      = 2 ** VERT_W;

  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_FREQ,
    ST_FWAIT,
    ST_LINK,
    ST_LINK2,
    ST_ACC,
    ST_DONE
  } kme_state_t;

endpackage

@@ src/kme_ram.sv @@
module kme_ram
  import kme_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/kruskal_mst_engine.sv @@
// Kruskal minimum spanning tree engine. Edges arrive one word per cycle while
// loading and are written to a 128-entry edge memory until a word with tlast; an
// edge beyond capacity is dropped and reported in the overflow flag of every
// result. The engine then picks edges in ascending signed weight (ties in
// arrival order) by rescanning the edge memory once per pick, one memory read
// per cycle, and checks each pick against a union-find memory (parent and rank
// per vertex) that is walked one read at a time. Each pick scans all n stored
// edges; each union-find step is a read request and a wait (at least one step
// per endpoint), and an accepted edge is linked with one or two writes and then
// handed over; input is held off until the last result is loaded into the
// output register. Each tree edge is emitted with the running total; an empty
// tree gives one word with edge_valid = 0. The user must write vertex_count
// only between graphs (not enforced); 0 acts as 1 and values above 32 as 32.
module kruskal_mst_engine
  import kme_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // edge_from[4:0], edge_to[9:5], edge_cost[25:10]
  input  logic        s_tuser,   // edge_present
  input  logic        s_tlast,   // final_edge
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // tree_from[4:0], tree_to[9:5], tree_cost[25:10],
                                 // running_total[46:26]
  output logic [1:0]  m_tuser,   // edge_valid[0], overflow[1]
  output logic        m_tlast    // last_result
);

  kme_state_t state, state_next;

  logic [VC_W-1:0]    vc_reg;
  logic [VC_W-1:0]    vc_eff;
  logic [VC_W-1:0]    target;
  logic [CNT_W-1:0]   cnt;
  logic               dropped;

  // edge memory ports
  logic               e_we;
  logic [EADDR_W-1:0] e_waddr;
  logic [EDGE_W-1:0]  e_wdata;
  logic [EADDR_W-1:0] e_raddr;
  logic [EDGE_W-1:0]  e_rdata;

  // union-find memory ports
  logic               u_we;
  logic [VERT_W-1:0]  u_waddr;
  logic [UF_W-1:0]    u_wdata;
  logic [UF_W-1:0]    u_rdata;

  // scan state
  logic [CNT_W-1:0]   scan_addr;
  logic               rd_v;
  logic [EADDR_W-1:0] rd_idx;
  logic               best_v;
  logic [EADDR_W-1:0] best_idx;
  logic [EDGE_W-1:0]  best_edge;
  logic               last_v;
  logic [EADDR_W-1:0] last_idx;
  logic [EDGE_W-1:0]  last_edge;

  // find / link state
  logic [UF_DEPTH-1:0] uvalid;
  logic [VERT_W-1:0]   cur;
  logic                fb;
  logic [VERT_W-1:0]   root_a;
  logic [RANK_W-1:0]   rank_a;
  logic [VERT_W-1:0]   root_b;
  logic [RANK_W-1:0]   rank_b;
  logic [VERT_W-1:0]   eff_par;
  logic [RANK_W-1:0]   eff_rank;

  // result state
  logic [TOTAL_W-1:0] cost_sum;
  logic [TOTAL_W-1:0] sum_new;
  logic [VC_W-1:0]    accepted;
  logic               pend_v;
  logic [EDGE_W-1:0]  pend_edge;
  logic [TOTAL_W-1:0] pend_sum;
  logic               slot_free;
  logic               out_load;

  logic               in_acc;
  logic               scan_end;
  logic               cand;
  logic               out_range;
  logic [VERT_W-1:0]  lst_to;
  logic signed [COST_W-1:0] sc_cost, bst_cost, lst_cost;

  // clamp the vertex count
  always_comb begin
    if (vc_reg == '0) begin
      vc_eff = VC_W'(1);
    end else if (vc_reg > VC_W'(MAX_VERTICES)) begin
      vc_eff = VC_W'(MAX_VERTICES);
    end else begin
      vc_eff = vc_reg;
    end
    target = vc_eff - VC_W'(1);
  end

  assign in_acc    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  // load the output register from a held edge or at the end of the graph
  assign out_load  = ((state == ST_ACC) && pend_v && slot_free) ||
                     ((state == ST_DONE) && slot_free);

  assign sc_cost  = e_rdata[EDGE_W-1:2*VERT_W];
  assign bst_cost = best_edge[EDGE_W-1:2*VERT_W];
  assign lst_to   = last_edge[2*VERT_W-1:VERT_W];
  assign lst_cost = last_edge[EDGE_W-1:2*VERT_W];

  // candidate: after the previous pick in (cost, index) order, below the best so far
  assign cand = rd_v &&
                (!last_v || (sc_cost > lst_cost) ||
                 ((sc_cost == lst_cost) && (rd_idx > last_idx))) &&
                (!best_v || (sc_cost < bst_cost));

  assign scan_end  = (scan_addr == cnt) && !rd_v;
  assign out_range = (VC_W'(best_edge[VERT_W-1:0]) >= vc_eff) ||
                     (VC_W'(best_edge[2*VERT_W-1:VERT_W]) >= vc_eff);

  // a vertex never written is its own root with rank zero
  assign eff_par  = uvalid[cur] ? u_rdata[VERT_W-1:0] : cur;
  assign eff_rank = uvalid[cur] ? u_rdata[UF_W-1:VERT_W] : '0;

  assign sum_new = cost_sum + {{(TOTAL_W-COST_W){lst_cost[COST_W-1]}}, lst_cost};

  kme_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_CAPACITY)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  kme_ram #(.WIDTH(UF_W), .DEPTH(UF_DEPTH)) u_uf_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .raddr (cur),
    .rdata (u_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_acc && s_tlast) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (target == '0) begin
          state_next = ST_DONE;
        end else if (scan_end) begin
          if (!best_v) begin
            state_next = ST_DONE;
          end else if (!out_range) begin
            state_next = ST_FREQ;
          end
        end
      end
      ST_FREQ: state_next = ST_FWAIT;
      ST_FWAIT: begin
        if (eff_par != cur) begin
          state_next = ST_FREQ;
        end else if (!fb) begin
          state_next = ST_FREQ;
        end else if (root_a == cur) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_LINK;
        end
      end
      ST_LINK: begin
        if (rank_a == rank_b) begin
          state_next = ST_LINK2;
        end else begin
          state_next = ST_ACC;
        end
      end
      ST_LINK2: state_next = ST_ACC;
      ST_ACC: begin
        if (!pend_v || slot_free) begin
          if (accepted + VC_W'(1) == target) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // memory controls
  always_comb begin
    s_tready = (state == ST_LOAD);
    e_we     = (state == ST_LOAD) && in_acc && s_tuser &&
               (cnt < CNT_W'(EDGE_CAPACITY));
    e_waddr  = cnt[EADDR_W-1:0];
    e_wdata  = s_tdata[EDGE_W-1:0];
    e_raddr  = scan_addr[EADDR_W-1:0];
    u_we     = 1'b0;
    u_waddr  = root_b;
    u_wdata  = {rank_b, root_a};
    unique case (state)
      ST_LINK: begin
        u_we = 1'b1;
        if (rank_a < rank_b) begin
          u_waddr = root_a;
          u_wdata = {rank_a, root_b};
        end
      end
      ST_LINK2: begin
        u_we    = 1'b1;
        u_waddr = root_a;
        u_wdata = {(rank_a == RANK_MAX) ? rank_a : rank_a + RANK_W'(1), root_a};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      vc_reg   <= VC_W'(VC_RESET);
      cnt      <= '0;
      dropped  <= 1'b0;
      rd_v     <= 1'b0;
      best_v   <= 1'b0;
      last_v   <= 1'b0;
      pend_v   <= 1'b0;
      uvalid   <= '0;
      m_tvalid <= 1'b0;
      accepted <= '0;
      cost_sum <= '0;
      fb       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        vc_reg <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_acc && s_tuser) begin
            if (cnt < CNT_W'(EDGE_CAPACITY)) begin
              cnt <= cnt + CNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
          end
          scan_addr <= '0;
          rd_v      <= 1'b0;
          best_v    <= 1'b0;
          last_v    <= 1'b0;
          pend_v    <= 1'b0;
          uvalid    <= '0;
          accepted  <= '0;
          cost_sum  <= '0;
        end
        ST_SCAN: begin
          // stream reads, keep the smallest candidate
          if (scan_addr < cnt) begin
            scan_addr <= scan_addr + CNT_W'(1);
            rd_v      <= 1'b1;
            rd_idx    <= scan_addr[EADDR_W-1:0];
          end else begin
            rd_v <= 1'b0;
          end
          if (cand) begin
            best_v    <= 1'b1;
            best_idx  <= rd_idx;
            best_edge <= e_rdata;
          end
          if (scan_end && best_v) begin
            last_v    <= 1'b1;
            last_idx  <= best_idx;
            last_edge <= best_edge;
            best_v    <= 1'b0;
            scan_addr <= '0;
            cur       <= best_edge[VERT_W-1:0];
            fb        <= 1'b0;
          end
        end
        ST_FWAIT: begin
          // follow parents up to the root
          if (eff_par != cur) begin
            cur <= eff_par;
          end else if (!fb) begin
            root_a <= cur;
            rank_a <= eff_rank;
            cur    <= lst_to;
            fb     <= 1'b1;
          end else begin
            root_b <= cur;
            rank_b <= eff_rank;
          end
        end
        ST_LINK: begin
          uvalid[u_waddr] <= 1'b1;
        end
        ST_LINK2: begin
          uvalid[u_waddr] <= 1'b1;
        end
        ST_ACC: begin
          // push the held result out, then hold the new one
          if (!pend_v || slot_free) begin
            if (pend_v) begin
              m_tdata  <= {1'b0, pend_sum, pend_edge};
              m_tuser  <= {dropped, 1'b1};
              m_tlast  <= 1'b0;
            end
            pend_v    <= 1'b1;
            pend_edge <= last_edge;
            pend_sum  <= sum_new;
            cost_sum  <= sum_new;
            accepted  <= accepted + VC_W'(1);
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            m_tlast  <= 1'b1;
            m_tuser  <= {dropped, pend_v};
            m_tdata  <= pend_v ? {1'b0, pend_sum, pend_edge} : '0;
            cnt      <= '0;
            dropped  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/kme_checker.sv @@
module kme_checker
  import kme_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // an empty-tree word closes the graph
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("empty result not marked last");

  // an empty-tree word carries zero payload
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("empty result has payload");

  // the last edge of a graph stops input (s_tready falls after it)
  a_stop_in: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken after final edge");

endmodule

bind kruskal_mst_engine kme_checker u_kme_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
